>>> hw/rtl/prgbdec_pkg.sv
// Shared types, codes and helper functions for the packed RGB16 pixel decoder.
// Depends on nothing; imported by packed_rgb16_pixel_decoder_unit.
package prgbdec_pkg;

    // Pixel geometry and colour-map depth.
    localparam int PIXEL_BITS  = 16;
    localparam int TABLE_DEPTH = 1 << PIXEL_BITS;
    localparam int CHAN_W      = 8;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_LINE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CMAP_LIMIT  = 3'd7;

    // Request codes of an input beat.
    localparam logic [1:0] REQ_ENTRY = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    // Raster stream phases.
    localparam logic [1:0] PH_PIXELS  = 2'd0;
    localparam logic [1:0] PH_PADDING = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    // Scaling divider: one quotient bit per cycle.
    localparam int DIV_STEPS = 8;
    localparam int DIV_BIT_W = 3;

    // One colour-map entry as stored.
    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_entry;

    // One result beat.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_end;
        logic              image_end;
        logic              status;
    } t_result;

    // Position and all-ones value of a mask span.
    typedef struct packed {
        logic [3:0]            lo;
        logic [PIXEL_BITS-1:0] maxv;
    } t_span;

    // Span of a mask from its lowest to its highest set bit; a zero mask has no span.
    function automatic t_span span_of(input logic [PIXEL_BITS-1:0] mask);
        t_span      s;
        logic [3:0] lo;
        logic [3:0] hi;
        logic [4:0] w;
        lo = '0;
        hi = '0;
        for (int i = PIXEL_BITS - 1; i >= 0; i--) begin
            if (mask[i]) lo = 4'(i);
        end
        for (int i = 0; i < PIXEL_BITS; i++) begin
            if (mask[i]) hi = 4'(i);
        end
        w      = 5'(hi) - 5'(lo) + 5'd1;
        s.lo   = lo;
        s.maxv = (mask == '0) ? '0 : 16'((17'd1 << w) - 17'd1);
        return s;
    endfunction

endpackage

>>> hw/rtl/packed_rgb16_pixel_decoder_unit.sv
// Packed RGB16 pixel decoder: pairs raster bytes into pixels and decodes them to RGB888.
// Depends on prgbdec_pkg for types, codes and the mask span function.
//
// After reset the colour-map memory (65536 entries) is cleared one entry per cycle, so the
// input stays not ready until that pass ends; configuration writes are taken throughout.
// An entry write, a first byte of a pixel or a padding byte is taken without leaving the
// idle state. A byte that completes a pixel reads the colour-map memory, and a colour-map
// hit or a black pixel then goes through the lookup and finish states to the output register;
// a pixel decoded by its masks also passes the shared restoring divider, one quotient bit per
// cycle for all three channels. An early end marker goes straight to the finish state. The
// output register holds a finished beat while the next input beats are taken.
module packed_rgb16_pixel_decoder_unit
    import prgbdec_pkg::*;
#(
    parameter int MAX_DIM = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [31:0]           i_entry_pixel,
    input  logic [15:0]           i_entry_red,
    input  logic [15:0]           i_entry_green,
    input  logic [15:0]           i_entry_blue,
    input  logic [7:0]            i_data_byte,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_pixel_red,
    output logic [CHAN_W-1:0]     o_pixel_green,
    output logic [CHAN_W-1:0]     o_pixel_blue,
    output logic                  o_row_end,
    output logic                  o_image_end,
    output logic                  o_status
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int RB_W  = DIM_W + 1;
    localparam int CMP_W = (RB_W > 16) ? RB_W : 16;
    localparam int X_W   = PIXEL_BITS + CHAN_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // Configuration registers.
    logic [15:0] r_red_mask;
    logic [15:0] r_green_mask;
    logic [15:0] r_blue_mask;
    logic [14:0] r_img_width;
    logic [14:0] r_img_height;
    logic [15:0] r_bytes_line;
    logic        r_lsb_first;
    logic [16:0] r_cmap_limit;

    // Control state.
    logic [2:0]            r_state;
    logic [PIXEL_BITS-1:0] r_clr_addr;
    logic [16:0]           r_entries;
    logic [7:0]            r_held;
    logic                  r_byte_phase;
    logic [DIM_W-1:0]      r_col;
    logic [DIM_W-1:0]      r_row;
    logic [15:0]           r_pad;
    logic [1:0]            r_phase;
    logic [DIV_BIT_W-1:0]  r_bit;
    logic                  r_out_valid;

    // Datapath registers.
    logic [PIXEL_BITS-1:0] r_pix;
    logic                  r_last_col;
    logic                  r_last_row;
    t_entry                r_rd_data;
    t_result               r_res;
    t_result               r_out;
    logic [X_W-1:0]        r_x [3];
    logic [PIXEL_BITS-1:0] r_d [3];
    logic [CHAN_W-1:0]     r_q [3];

    // Colour-map memory.
    t_entry r_table [TABLE_DEPTH];

    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_entry_ok;
    logic                  w_mem_we;
    logic [PIXEL_BITS-1:0] w_mem_waddr;
    t_entry                w_mem_wdata;
    logic                  w_mem_re;
    logic [PIXEL_BITS-1:0] w_pix;
    logic [DIM_W-1:0]      w_width;
    logic [DIM_W-1:0]      w_height;
    logic                  w_last_col;
    logic                  w_last_row;
    logic [15:0]           w_linepad;
    logic [CMP_W-1:0]      w_row_bytes;
    logic [CMP_W-1:0]      w_bpl_ext;
    logic [PIXEL_BITS-1:0] w_mask [3];
    t_span                 w_span [3];
    logic [PIXEL_BITS-1:0] w_field [3];
    logic [X_W-1:0]        w_x [3];
    logic [PIXEL_BITS-1:0] w_d [3];
    logic [PIXEL_BITS-1:0] w_span_all;
    logic                  w_black;
    t_result               w_look_res;
    logic [X_W-1:0]        w_sh [3];
    logic                  w_ge [3];
    logic [CHAN_W-1:0]     w_q_next [3];

    // Handshakes.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_mask   <= 16'hF800;
            r_green_mask <= 16'h07E0;
            r_blue_mask  <= 16'h001F;
            r_img_width  <= 15'd1;
            r_img_height <= 15'd1;
            r_bytes_line <= 16'd2;
            r_lsb_first  <= 1'b1;
            r_cmap_limit <= 17'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RED_MASK:   r_red_mask   <= i_cfg_data[15:0];
                CFG_GREEN_MASK: r_green_mask <= i_cfg_data[15:0];
                CFG_BLUE_MASK:  r_blue_mask  <= i_cfg_data[15:0];
                CFG_IMG_WIDTH:  r_img_width  <= i_cfg_data[14:0];
                CFG_IMG_HEIGHT: r_img_height <= i_cfg_data[14:0];
                CFG_BYTES_LINE: r_bytes_line <= i_cfg_data[15:0];
                CFG_LSB_FIRST:  r_lsb_first  <= i_cfg_data[0];
                CFG_CMAP_LIMIT: r_cmap_limit <= i_cfg_data[16:0];
            endcase
        end
    end

    // Clamped image dimensions; zero counts as one.
    always_comb begin
        if (r_img_width == '0) begin
            w_width = DIM_W'(1);
        end else if (17'(r_img_width) > 17'(MAX_DIM)) begin
            w_width = DIM_W'(MAX_DIM);
        end else begin
            w_width = DIM_W'(r_img_width);
        end
        if (r_img_height == '0) begin
            w_height = DIM_W'(1);
        end else if (17'(r_img_height) > 17'(MAX_DIM)) begin
            w_height = DIM_W'(MAX_DIM);
        end else begin
            w_height = DIM_W'(r_img_height);
        end
    end

    // Pixel assembly, row position and line padding for a completing byte.
    assign w_pix = r_lsb_first ? {i_data_byte, r_held} : {r_held, i_data_byte};
    assign w_last_col = ((RB_W)'(r_col) + (RB_W)'(1)) >= (RB_W)'(w_width);
    assign w_last_row = w_last_col && (((RB_W)'(r_row) + (RB_W)'(1)) >= (RB_W)'(w_height));
    assign w_row_bytes = CMP_W'({w_width, 1'b0});
    assign w_bpl_ext   = CMP_W'(r_bytes_line);
    assign w_linepad   = (w_bpl_ext > w_row_bytes) ? 16'(w_bpl_ext - w_row_bytes) : 16'd0;

    // Memory port control: the clearing pass owns the write port after reset.
    assign w_entry_ok  = (r_entries < r_cmap_limit);
    assign w_mem_we    = (r_state == S_CLEAR)
                      || (w_in_acc && (i_req_type == REQ_ENTRY) && w_entry_ok
                          && (i_entry_pixel[31:16] == '0));
    assign w_mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : i_entry_pixel[15:0];
    assign w_mem_wdata = (r_state == S_CLEAR) ? '0
                       : {1'b1, i_entry_red[15:8], i_entry_green[15:8], i_entry_blue[15:8]};
    assign w_mem_re    = w_in_acc && (i_req_type == REQ_DATA) && (r_phase == PH_PIXELS)
                      && r_byte_phase;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_table[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_table[w_pix];
        end
    end

    // Channel extraction from the mask spans.
    assign w_mask[0] = r_red_mask;
    assign w_mask[1] = r_green_mask;
    assign w_mask[2] = r_blue_mask;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_span[c]  = span_of(w_mask[c]);
            w_field[c] = (r_pix >> w_span[c].lo) & w_span[c].maxv;
            w_x[c]     = {w_field[c], 8'b0} - X_W'(w_field[c]);
            w_d[c]     = (w_span[c].maxv == '0) ? PIXEL_BITS'(1) : w_span[c].maxv;
        end
        w_span_all = (w_span[0].maxv << w_span[0].lo)
                   | (w_span[1].maxv << w_span[1].lo)
                   | (w_span[2].maxv << w_span[2].lo);
        w_black = (r_pix & ~w_span_all) != '0;
    end

    // Result after the lookup; colours stay zero for the divider path and for black pixels that miss the colour map.
    always_comb begin
        w_look_res           = '0;
        w_look_res.row_end   = r_last_col;
        w_look_res.image_end = r_last_row;
        if (r_rd_data.valid) begin
            w_look_res.red   = r_rd_data.red;
            w_look_res.green = r_rd_data.green;
            w_look_res.blue  = r_rd_data.blue;
        end
    end

    // Restoring division step: one quotient bit per channel.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sh[c]     = X_W'(r_d[c]) << r_bit;
            w_ge[c]     = (r_x[c] >= w_sh[c]);
            w_q_next[c] = {r_q[c][CHAN_W-2:0], w_ge[c]};
        end
    end

    // Control sequencer and raster stream state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_entries    <= '0;
            r_held       <= '0;
            r_byte_phase <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_pad        <= '0;
            r_phase      <= PH_PIXELS;
            r_bit        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        unique case (i_req_type)
                            REQ_ENTRY: begin
                                if (w_entry_ok) r_entries <= r_entries + 1'b1;
                            end
                            REQ_END: begin
                                r_held       <= '0;
                                r_byte_phase <= 1'b0;
                                r_col        <= '0;
                                r_row        <= '0;
                                r_pad        <= '0;
                                r_phase      <= PH_PIXELS;
                                if (r_phase != PH_DONE) r_state <= S_FIN;
                            end
                            REQ_DATA: begin
                                if (r_phase == PH_PADDING) begin
                                    if (r_pad > 16'd1) begin
                                        r_pad <= r_pad - 1'b1;
                                    end else begin
                                        r_pad   <= '0;
                                        r_phase <= PH_PIXELS;
                                    end
                                end else if (r_phase == PH_PIXELS) begin
                                    if (!r_byte_phase) begin
                                        r_held       <= i_data_byte;
                                        r_byte_phase <= 1'b1;
                                    end else begin
                                        r_byte_phase <= 1'b0;
                                        r_state      <= S_LOOK;
                                        if (w_last_row) begin
                                            r_phase <= PH_DONE;
                                        end else if (w_last_col) begin
                                            r_col <= '0;
                                            r_row <= r_row + 1'b1;
                                            if (w_linepad != '0) begin
                                                r_pad   <= w_linepad;
                                                r_phase <= PH_PADDING;
                                            end
                                        end else begin
                                            r_col <= r_col + 1'b1;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOOK: begin
                    if (r_rd_data.valid || w_black) begin
                        r_state <= S_FIN;
                    end else begin
                        r_bit   <= DIV_BIT_W'(DIV_STEPS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: pixel capture, divider and result staging.
    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_pix      <= w_pix;
            r_last_col <= w_last_col;
            r_last_row <= w_last_row;
        end
        if (w_in_acc && (i_req_type == REQ_END)) begin
            r_res <= t_result'{red: '0, green: '0, blue: '0, row_end: 1'b0,
                               image_end: 1'b1, status: 1'b1};
        end
        if (r_state == S_LOOK) begin
            r_res <= w_look_res;
            for (int c = 0; c < 3; c++) begin
                r_x[c] <= w_x[c];
                r_d[c] <= w_d[c];
                r_q[c] <= '0;
            end
        end
        if (r_state == S_DIV) begin
            for (int c = 0; c < 3; c++) begin
                if (w_ge[c]) r_x[c] <= r_x[c] - w_sh[c];
                r_q[c] <= w_q_next[c];
            end
            if (r_bit == '0) begin
                r_res.red   <= w_q_next[0];
                r_res.green <= w_q_next[1];
                r_res.blue  <= w_q_next[2];
            end
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_out <= r_res;
        end
    end

    // Output beat.
    assign o_out_valid   = r_out_valid;
    assign o_pixel_red   = r_out.red;
    assign o_pixel_green = r_out.green;
    assign o_pixel_blue  = r_out.blue;
    assign o_row_end     = r_out.row_end;
    assign o_image_end   = r_out.image_end;
    assign o_status      = r_out.status;

`ifndef SYNTHESIS
    // No result can appear while the colour map is still being cleared.
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result beat during colour-map clearing pass");

    // A half-assembled pixel only exists in the pixel phase.
    a_half_pixel_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_phase |-> (r_phase == PH_PIXELS))
        else $error("held byte outside pixel phase");

    // The padding phase always has bytes left to skip.
    a_pad_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PADDING) |-> (r_pad != '0))
        else $error("padding phase with empty pad count");

    // The last divider step hands over to the output stage.
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && (r_bit == '0)) |=> (r_state == S_FIN))
        else $error("divider did not finish after its last step");

    // An error beat is black, ends the image and is not a row end.
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_image_end && !o_row_end && (o_pixel_red == '0)
            && (o_pixel_green == '0) && (o_pixel_blue == '0)))
        else $error("malformed error beat");
`endif

endmodule
